// File: rtl/assert_macros.svh
// Assertion macros used by the top level of the pair mass block.
// Depends on nothing; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define TBIM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Check that a condition implies another one on the next edge
`define TBIM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TBIM_ASSERT(lbl, clk, rst_n, prop)
`define TBIM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/tbim_pkg.sv
// Shared constants of the two-body invariant mass block.
// Depends on nothing.
`timescale 1ns / 1ps
package tbim_pkg;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int MASS_W            = 18;
    localparam int MOM_W             = 19;
    localparam int OUT_W             = 28;
    localparam int IN_DATA_W         = 152;
    localparam int OUT_DATA_W        = 32;
    // Guard bits of the remainder in each square root stage
    localparam int SQRT_GUARD        = 3;
endpackage

// File: rtl/tbim_sqrt_pipe.sv
// Pipelined floor square root, one result bit per register stage.
// Depends on tbim_pkg for the remainder guard width.
`timescale 1ns / 1ps
module tbim_sqrt_pipe #(
    parameter int IN_W   = 56,
    parameter int SIDE_W = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [IN_W-1:0]     i_rad,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_vld,
    output logic [IN_W/2-1:0]   o_root,
    output logic [SIDE_W-1:0]   o_side
);
    localparam int RW  = IN_W / 2;
    localparam int RMW = RW + tbim_pkg::SQRT_GUARD;

    logic              stg_vld  [0:RW];
    logic [IN_W-1:0]   stg_rad  [0:RW];
    logic [RMW-1:0]    stg_rem  [0:RW];
    logic [RW-1:0]     stg_root [0:RW];
    logic [SIDE_W-1:0] stg_side [0:RW];

    // Feed the first stage from the ports
    assign stg_vld[0]  = i_vld;
    assign stg_rad[0]  = i_rad;
    assign stg_rem[0]  = '0;
    assign stg_root[0] = '0;
    assign stg_side[0] = i_side;

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RMW-1:0] n_rem;
        logic [RMW-1:0] trial;
        logic [RW-1:0]  n_root;

        // Bring down two radicand bits and try the next root bit
        always_comb begin
            n_rem  = {stg_rem[k][RMW-3:0], stg_rad[k][IN_W-1 -: 2]};
            trial  = {{(RMW-RW-2){1'b0}}, stg_root[k], 2'b01};
            n_root = {stg_root[k][RW-2:0], 1'b0};
            if (n_rem >= trial) begin
                n_rem  = n_rem - trial;
                n_root = {stg_root[k][RW-2:0], 1'b1};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                stg_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                stg_vld[k+1] <= stg_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                stg_rad[k+1]  <= {stg_rad[k][IN_W-3:0], 2'b00};
                stg_rem[k+1]  <= n_rem;
                stg_root[k+1] <= n_root;
                stg_side[k+1] <= stg_side[k];
            end
        end
    end

    assign o_vld  = stg_vld[RW];
    assign o_root = stg_root[RW];
    assign o_side = stg_side[RW];
endmodule

// File: rtl/two_body_invariant_mass.sv
// Two-body invariant mass: top level with squaring, energy and mass stages.
// Depends on tbim_pkg, tbim_sqrt_pipe and assert_macros.svh.
//
// Usage:
//   The slave channel takes one particle pair per word; the master channel
//   returns the pair mass in tdata and the negative square flag in tuser.
//   One word is accepted every cycle while the master side takes results.
//   A word passes stages 1 and 2, the bit-per-stage square root pipelines
//   of the energies, stages 3 to 5, the bit-per-stage square root pipeline
//   of the mass and the output register.
//   The whole pipeline advances on one enable: when the output register
//   holds a word that the receiver does not take, every stage holds and
//   s_axis_tready drops, so nothing is lost or repeated.
//   Reset clears all valid bits; the pipeline is empty afterwards and
//   ready at once. There is no configuration.
//   A negative mass square, which can arise from the floored energies,
//   gives a pair mass of zero with the flag set; a mass that does not fit
//   in 28 bits saturates.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module two_body_invariant_mass #(
    parameter int FRACTION_BITS = tbim_pkg::FRACTION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // mass_a, px_a, py_a, pz_a, mass_b, px_b, py_b, pz_b, zero pad
    input  logic [tbim_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pair_mass, zero pad
    output logic [tbim_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // negative_square
    output logic                            m_axis_tuser
);
    localparam int MW   = tbim_pkg::MASS_W;
    localparam int PW   = tbim_pkg::MOM_W;
    localparam int F2   = 2 * FRACTION_BITS;
    localparam int SQ_W = 2 * PW - 1;
    localparam int SW   = PW + 1;
    localparam int PQ_W = 2 * SW - 1;
    localparam int ER_W = 40 + F2;
    localparam int EW   = ER_W / 2;
    localparam int ES_W = EW + 1;
    localparam int P2_W = PQ_W + 2 + F2;
    localparam int QW   = 2 * ES_W;
    localparam int RW   = QW / 2;
    localparam int OW   = tbim_pkg::OUT_W;
    localparam int CW   = (RW > OW) ? RW : OW;
    localparam logic [CW-1:0] OUT_MAX = CW'((64'd1 << OW) - 64'd1);

    logic en;
    logic r_out_vld;
    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;

    // Unpack the input word
    logic [MW-1:0]        mass [0:1];
    logic signed [PW-1:0] mom  [0:1][0:2];
    assign mass[0]   = s_axis_tdata[17:0];
    assign mom[0][0] = s_axis_tdata[36:18];
    assign mom[0][1] = s_axis_tdata[55:37];
    assign mom[0][2] = s_axis_tdata[74:56];
    assign mass[1]   = s_axis_tdata[92:75];
    assign mom[1][0] = s_axis_tdata[111:93];
    assign mom[1][1] = s_axis_tdata[130:112];
    assign mom[1][2] = s_axis_tdata[149:131];

    // Stage 1: square every component, sum the momenta
    logic                 r_s1_vld;
    logic [SQ_W-1:0]      r_s1_sq [0:1][0:3];
    logic signed [SW-1:0] r_s1_ps [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= s_axis_tvalid;
        end
    end

    for (genvar p = 0; p < 2; p++) begin : g_part
        logic [2*MW-1:0]      msq;
        logic signed [2*PW-1:0] psq [0:2];
        assign msq = (2*MW)'(mass[p]) * (2*MW)'(mass[p]);
        for (genvar c = 0; c < 3; c++) begin : g_comp
            assign psq[c] = (2*PW)'(mom[p][c]) * (2*PW)'(mom[p][c]);
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_s1_sq[p][c+1] <= psq[c][SQ_W-1:0];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s1_sq[p][0] <= SQ_W'(msq);
            end
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_psum
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s1_ps[c] <= SW'(mom[0][c]) + SW'(mom[1][c]);
            end
        end
    end

    // Stage 2: energy radicands, squares of the momentum sum
    logic            r_s2_vld;
    logic [ER_W-1:0] r_s2_rad [0:1];
    logic [PQ_W-1:0] r_s2_pq  [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    for (genvar p = 0; p < 2; p++) begin : g_rad
        logic [ER_W-1:0] tot;
        assign tot = ER_W'(r_s1_sq[p][0]) + ER_W'(r_s1_sq[p][1])
                   + ER_W'(r_s1_sq[p][2]) + ER_W'(r_s1_sq[p][3]);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s2_rad[p] <= tot << F2;
            end
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_psq
        logic signed [2*SW-1:0] sq;
        assign sq = (2*SW)'(r_s1_ps[c]) * (2*SW)'(r_s1_ps[c]);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s2_pq[c] <= sq[PQ_W-1:0];
            end
        end
    end

    // Energies of both particles; the momentum squares ride along
    logic              ea_vld, eb_vld;
    logic [EW-1:0]     ea, eb;
    logic [2*PQ_W-1:0] side_a;
    logic [PQ_W-1:0]   side_b;

    tbim_sqrt_pipe #(.IN_W(ER_W), .SIDE_W(2 * PQ_W)) u_sqrt_ea (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_s2_vld),
        .i_rad   (r_s2_rad[0]),
        .i_side  ({r_s2_pq[1], r_s2_pq[0]}),
        .o_vld   (ea_vld),
        .o_root  (ea),
        .o_side  (side_a)
    );

    tbim_sqrt_pipe #(.IN_W(ER_W), .SIDE_W(PQ_W)) u_sqrt_eb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_s2_vld),
        .i_rad   (r_s2_rad[1]),
        .i_side  (r_s2_pq[2]),
        .o_vld   (eb_vld),
        .o_root  (eb),
        .o_side  (side_b)
    );

    // Stage 3: energy sum and scaled momentum square
    logic            r_s3_vld;
    logic [ES_W-1:0] r_s3_es;
    logic [P2_W-1:0] r_s3_p2;
    logic [P2_W-1:0] p2_sum;
    assign p2_sum = P2_W'(side_a[PQ_W-1:0]) + P2_W'(side_a[2*PQ_W-1:PQ_W])
                  + P2_W'(side_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (en) begin
            r_s3_vld <= ea_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_es <= ES_W'(ea) + ES_W'(eb);
            r_s3_p2 <= p2_sum << F2;
        end
    end

    // Stage 4: square of the energy sum
    logic          r_s4_vld;
    logic [QW-1:0] r_s4_e2;
    logic [QW-1:0] r_s4_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (en) begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_e2 <= QW'(r_s3_es) * QW'(r_s3_es);
            r_s4_p2 <= QW'(r_s3_p2);
        end
    end

    // Stage 5: mass square, clamped at zero and flagged when negative
    logic          r_s5_vld;
    logic [QW-1:0] r_s5_q;
    logic          r_s5_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else if (en) begin
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_s4_p2 > r_s4_e2) begin
                r_s5_q   <= '0;
                r_s5_neg <= 1'b1;
            end else begin
                r_s5_q   <= r_s4_e2 - r_s4_p2;
                r_s5_neg <= 1'b0;
            end
        end
    end

    // Pair mass root
    logic          m_vld;
    logic [RW-1:0] m_root;
    logic          m_neg;

    tbim_sqrt_pipe #(.IN_W(QW), .SIDE_W(1)) u_sqrt_m (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_s5_vld),
        .i_rad   (r_s5_q),
        .i_side  (r_s5_neg),
        .o_vld   (m_vld),
        .o_root  (m_root),
        .o_side  (m_neg)
    );

    // Output register with saturation
    logic [OW-1:0] r_out_mass;
    logic          r_out_neg;
    logic [CW-1:0] root_c;
    assign root_c = CW'(m_root);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_mass <= (root_c > OUT_MAX) ? OUT_MAX[OW-1:0] : root_c[OW-1:0];
            r_out_neg  <= m_neg;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(tbim_pkg::OUT_DATA_W-OW){1'b0}}, r_out_mass};
    assign m_axis_tuser  = r_out_neg;

    // Both energy pipelines carry the same word
    `TBIM_ASSERT(a_energy_lockstep, i_clk, i_rst_n, ea_vld == eb_vld)
    // A clamped square always reports a zero mass
    `TBIM_ASSERT(a_neg_zero, i_clk, i_rst_n, !(r_out_vld && r_out_neg) || r_out_mass == '0)
    // A stall freezes the valid bits of stages 1 and 5
    `TBIM_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !en, $stable(r_s1_vld) && $stable(r_s5_vld))
endmodule
